// ===== sv/stq_pkg.sv =====
package stq_pkg;

    localparam int TW = 48;
    localparam int DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        CMD_SCHED    = 3'd0,
        CMD_CANCEL   = 3'd1,
        CMD_CAN_HDL  = 3'd2,
        CMD_EXPIRE   = 3'd3,
        CMD_SET_IVL  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        COP_HOLD   = 2'd0,
        COP_INS    = 2'd1,
        COP_ROT    = 2'd2,
        COP_SETPER = 2'd3
    } t_cop;

    typedef struct packed {
        logic [2:0]    cmd;
        logic [15:0]   handler_tag;
        logic [31:0]   act_token;
        logic [TW-1:0] time_value;
        logic [TW-1:0] interval;
        logic [3:0]    tmr_num;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        kind;
        logic [3:0]  id_out;
        logic [15:0] handler_out;
        logic [31:0] act_out;
        logic        recurring;
        logic [4:0]  count;
        logic        last;
    } t_res;

    // timer entry held in one list slot
    typedef struct packed {
        logic [TW-1:0] dl;
        logic [TW-1:0] per;
        logic [15:0]   owner;
        logic [31:0]   tok;
    } t_ent;

    // broadcast control to every slot of the chain
    typedef struct packed {
        t_cop          op;
        logic [TW-1:0] key;
        logic          keep;
        t_ent          ent;
    } t_cctl;

endpackage

// ===== sv/stq_cell.sv =====
module stq_cell #(
    parameter int IDW = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stq_pkg::t_cctl      i_ctl,
    input  logic [IDW-1:0]      i_new_id,
    input  logic                i_is_tail,
    input  logic                i_prev_le,
    input  logic                i_prev_vld,
    input  logic [IDW-1:0]      i_prev_id,
    input  stq_pkg::t_ent       i_prev_ent,
    input  logic                i_next_vld,
    input  logic [IDW-1:0]      i_next_id,
    input  stq_pkg::t_ent       i_next_ent,
    output logic                o_vld,
    output logic [IDW-1:0]      o_id,
    output stq_pkg::t_ent       o_ent,
    output logic                o_le
);

    logic           r_vld;
    logic [IDW-1:0] r_id;
    stq_pkg::t_ent  r_ent;

    // slot sorts at or before the new key
    assign o_le  = r_vld && (r_ent.dl <= i_ctl.key);
    assign o_vld = r_vld;
    assign o_id  = r_id;
    assign o_ent = r_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            case (i_ctl.op)
                stq_pkg::COP_INS: begin
                    // hold when at or before the key, else take the new entry or shift right
                    if (!o_le) begin
                        if (i_prev_le) begin
                            r_vld <= 1'b1;
                            r_id  <= i_new_id;
                            r_ent <= i_ctl.ent;
                        end else begin
                            r_vld <= i_prev_vld;
                            r_id  <= i_prev_id;
                            r_ent <= i_prev_ent;
                        end
                    end
                end
                stq_pkg::COP_ROT: begin
                    // shift left, tail takes the old head when kept
                    if (i_is_tail) begin
                        r_vld <= i_ctl.keep;
                        r_id  <= i_new_id;
                        r_ent <= i_ctl.ent;
                    end else begin
                        r_vld <= i_next_vld;
                        r_id  <= i_next_id;
                        r_ent <= i_next_ent;
                    end
                end
                stq_pkg::COP_SETPER: begin
                    if (r_vld && r_id == i_new_id) begin
                        r_ent.per <= i_ctl.ent.per;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/stq_mod.sv =====
module stq_mod (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [stq_pkg::TW-1:0]  i_a,
    input  logic [stq_pkg::TW-1:0]  i_p,
    output logic                    o_done,
    output logic [stq_pkg::TW-1:0]  o_rem
);

    localparam int KW = $clog2(stq_pkg::TW);

    logic                   r_busy;
    logic [KW-1:0]          r_k;
    logic [stq_pkg::TW-1:0] r_a;
    logic [stq_pkg::TW-1:0] r_p;
    logic [stq_pkg::TW-1:0] r_rem;
    logic [stq_pkg::TW:0]   w_t;
    logic [stq_pkg::TW:0]   w_d;

    // one restoring remainder step per cycle
    always_comb begin
        w_t = {r_rem, r_a[stq_pkg::TW-1]};
        w_d = w_t - {1'b0, r_p};
        if (w_t >= {1'b0, r_p}) begin
            w_t = w_d;
        end
    end

    assign o_rem  = w_t[stq_pkg::TW-1:0];
    assign o_done = r_busy && (r_k == KW'(stq_pkg::TW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_k    <= '0;
            r_a    <= i_a;
            r_p    <= i_p;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= w_t[stq_pkg::TW-1:0];
            r_a   <= {r_a[stq_pkg::TW-2:0], 1'b0};
            r_k   <= r_k + KW'(1);
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/sorted_timer_queue.sv =====
// Sorted timer queue. Requests enter on the in channel (i_in_valid /
// o_in_ready, payload i_in_req) and results leave on the out channel
// (o_out_valid / i_out_ready, payload o_out_res); one request is worked at
// a time. Pending timers sit in a chain of slots sorted by deadline.
// Schedule, set interval, unknown requests and cancels of an id that is
// not queued are answered from the command state. Other cancels by id and
// cancels by handler walk the whole list, one slot per cycle, then answer.
// Expire retires each due timer in turn; for a recurring one the
// bit-serial remainder unit (48 steps) advances its deadline before it is
// put back in the list, then answers with a closing count. The next
// request is taken after the last result is placed in the output
// register.
// Reset empties the list and fills the free id list with ids 0 up to
// DEPTH-1 at once. When the receiver stalls, the result waits in the output
// register; the block stops at its next result until the waiting one is taken.
module sorted_timer_queue #(
    parameter int DEPTH = stq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  stq_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output stq_pkg::t_res o_out_res
);

    localparam int IDW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CMD  = 7'b0000010,
        S_ROT  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_INS  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state         r_state;
    stq_pkg::t_req  r_req;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  r_fcnt;
    logic [CW-1:0]  r_walk;
    logic [CW-1:0]  r_n;
    logic [IDW-1:0] r_free [DEPTH];
    logic [DEPTH-1:0] r_qflag;
    logic [DEPTH-1:0] r_done;
    logic [31:0]    r_tok;
    stq_pkg::t_ent  r_hold;
    logic [IDW-1:0] r_hid;
    logic           r_ovld;
    stq_pkg::t_res  r_ores;

    logic           w_vld [DEPTH];
    logic [IDW-1:0] w_id  [DEPTH];
    stq_pkg::t_ent  w_ent [DEPTH];
    logic           w_le  [DEPTH];
    logic [DEPTH-1:0] w_tail;

    stq_pkg::t_cctl w_ctl;
    logic [IDW-1:0] w_new_id;
    logic           w_free;
    logic           w_emit;
    stq_pkg::t_res  w_res;
    logic [IDW-1:0] w_tidx;
    logic           w_tbad;
    logic           w_due;
    logic           w_rec;
    logic           w_mstart;
    logic           w_mdone;
    logic [stq_pkg::TW-1:0] w_rem;
    logic [stq_pkg::TW:0]   w_sum;

    assign w_free   = !r_ovld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_res   = r_ores;
    assign w_tidx = IDW'(r_req.tmr_num);
    assign w_tbad = (32'(r_req.tmr_num) >= 32'(DEPTH)) || !r_qflag[w_tidx];
    assign w_rec  = (w_ent[0].per != '0);
    assign w_due  = (r_cnt != '0) && (32'(r_n) < 32'(DEPTH))
                  && (w_ent[0].dl <= r_req.time_value) && !r_done[w_id[0]];
    assign w_sum  = {1'b0, r_req.time_value} + {1'b0, r_hold.per} - {1'b0, w_rem};

    // chain of sorted slots
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_tail[g] = (r_cnt == CW'(g + 1));
        if (g == 0) begin : g_first
            stq_cell #(.IDW(IDW)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
                .i_new_id(w_new_id), .i_is_tail(w_tail[g]),
                .i_prev_le(1'b1), .i_prev_vld(1'b1), .i_prev_id(w_new_id),
                .i_prev_ent(w_ctl.ent),
                .i_next_vld((DEPTH > 1) ? w_vld[(g + 1) % DEPTH] : 1'b0),
                .i_next_id(w_id[(g + 1) % DEPTH]),
                .i_next_ent(w_ent[(g + 1) % DEPTH]),
                .o_vld(w_vld[g]), .o_id(w_id[g]), .o_ent(w_ent[g]), .o_le(w_le[g])
            );
        end else begin : g_rest
            stq_cell #(.IDW(IDW)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
                .i_new_id(w_new_id), .i_is_tail(w_tail[g]),
                .i_prev_le(w_le[g - 1]), .i_prev_vld(w_vld[g - 1]),
                .i_prev_id(w_id[g - 1]), .i_prev_ent(w_ent[g - 1]),
                .i_next_vld((g < DEPTH - 1) ? w_vld[(g + 1) % DEPTH] : 1'b0),
                .i_next_id(w_id[(g + 1) % DEPTH]),
                .i_next_ent(w_ent[(g + 1) % DEPTH]),
                .o_vld(w_vld[g]), .o_id(w_id[g]), .o_ent(w_ent[g]), .o_le(w_le[g])
            );
        end
    end

    stq_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(r_req.time_value - w_ent[0].dl), .i_p(w_ent[0].per),
        .o_done(w_mdone), .o_rem(w_rem)
    );

    // decide slot operation and result for this cycle
    always_comb begin
        w_ctl      = '0;
        w_ctl.op   = stq_pkg::COP_HOLD;
        w_ctl.key  = r_req.time_value;
        w_ctl.ent  = w_ent[0];
        w_new_id   = w_id[0];
        w_emit     = 1'b0;
        w_res      = '0;
        w_res.last = 1'b1;
        w_mstart   = 1'b0;
        case (r_state)
            S_CMD: begin
                case (r_req.cmd)
                    stq_pkg::CMD_SCHED: begin
                        w_emit = w_free;
                        if (r_fcnt == '0) begin
                            w_res.status = stq_pkg::ST_FULL;
                        end else begin
                            w_res.id_out = 4'(r_free[0]);
                            w_ctl.op     = w_free ? stq_pkg::COP_INS : stq_pkg::COP_HOLD;
                            w_ctl.ent    = '{dl: r_req.time_value, per: r_req.interval,
                                             owner: r_req.handler_tag,
                                             tok: r_req.act_token};
                            w_new_id     = r_free[0];
                        end
                    end
                    stq_pkg::CMD_CANCEL: begin
                        w_emit = w_free && w_tbad;
                        w_res.status = stq_pkg::ST_BAD;
                        w_res.id_out = r_req.tmr_num;
                    end
                    stq_pkg::CMD_CAN_HDL, stq_pkg::CMD_EXPIRE: begin
                    end
                    stq_pkg::CMD_SET_IVL: begin
                        w_emit = w_free;
                        w_res.id_out = r_req.tmr_num;
                        if (32'(r_req.tmr_num) >= 32'(DEPTH)) begin
                            w_res.status = stq_pkg::ST_BAD;
                        end else begin
                            w_ctl.op      = w_free ? stq_pkg::COP_SETPER : stq_pkg::COP_HOLD;
                            w_ctl.ent.per = r_req.interval;
                            w_new_id      = w_tidx;
                        end
                    end
                    default: begin
                        w_emit = w_free;
                    end
                endcase
            end
            S_ROT: begin
                if (r_walk != '0) begin
                    w_ctl.op = stq_pkg::COP_ROT;
                    if (r_req.cmd == stq_pkg::CMD_CANCEL) begin
                        w_ctl.keep = (w_id[0] != w_tidx);
                    end else begin
                        w_ctl.keep = (w_ent[0].owner != r_req.handler_tag);
                    end
                end
            end
            S_CHK: begin
                if (w_due && w_free) begin
                    w_emit            = 1'b1;
                    w_res.kind        = 1'b1;
                    w_res.last        = 1'b0;
                    w_res.id_out      = 4'(w_id[0]);
                    w_res.handler_out = w_ent[0].owner;
                    w_res.act_out     = w_ent[0].tok;
                    w_res.recurring   = w_rec;
                    w_ctl.op          = stq_pkg::COP_ROT;
                    w_ctl.keep        = 1'b0;
                    w_mstart          = w_rec;
                end
            end
            S_INS: begin
                w_ctl.op  = stq_pkg::COP_INS;
                w_ctl.key = r_hold.dl;
                w_ctl.ent = r_hold;
                w_new_id  = r_hid;
            end
            S_FIN: begin
                w_emit = w_free;
                if (r_req.cmd == stq_pkg::CMD_CANCEL) begin
                    w_res.id_out  = r_req.tmr_num;
                    w_res.act_out = r_tok;
                end else begin
                    w_res.count = 5'(r_n);
                end
            end
            default: begin
            end
        endcase
    end

    // sequence the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_fcnt  <= CW'(DEPTH);
            r_qflag <= '0;
            r_ovld  <= 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                r_free[k] <= IDW'(k);
            end
        end else begin
            if (w_emit) begin
                r_ovld <= 1'b1;
                r_ores <= w_res;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_req;
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    r_n    <= '0;
                    r_done <= '0;
                    r_walk <= r_cnt;
                    case (r_req.cmd)
                        stq_pkg::CMD_SCHED: begin
                            if (w_free) begin
                                r_state <= S_IDLE;
                                if (r_fcnt != '0) begin
                                    for (int k = 0; k < DEPTH - 1; k++) begin
                                        r_free[k] <= r_free[k + 1];
                                    end
                                    r_fcnt <= r_fcnt - CW'(1);
                                    r_cnt  <= r_cnt + CW'(1);
                                    r_qflag[r_free[0]] <= 1'b1;
                                end
                            end
                        end
                        stq_pkg::CMD_CANCEL: begin
                            if (!w_tbad) begin
                                r_state <= S_ROT;
                            end else if (w_free) begin
                                r_state <= S_IDLE;
                            end
                        end
                        stq_pkg::CMD_CAN_HDL: r_state <= S_ROT;
                        stq_pkg::CMD_EXPIRE:  r_state <= S_CHK;
                        default: begin
                            if (w_free) begin
                                r_state <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_ROT: begin
                    if (r_walk == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_walk <= r_walk - CW'(1);
                        // drop the head: free its id
                        if (!w_ctl.keep) begin
                            r_free[r_fcnt[IDW-1:0]] <= w_id[0];
                            r_fcnt <= r_fcnt + CW'(1);
                            r_cnt  <= r_cnt - CW'(1);
                            r_qflag[w_id[0]] <= 1'b0;
                            r_n    <= r_n + CW'(1);
                            r_tok  <= w_ent[0].tok;
                        end
                    end
                end
                S_CHK: begin
                    if (!w_due) begin
                        r_state <= S_FIN;
                    end else if (w_free) begin
                        r_n    <= r_n + CW'(1);
                        r_cnt  <= r_cnt - CW'(1);
                        r_done[w_id[0]] <= 1'b1;
                        r_hold <= w_ent[0];
                        r_hid  <= w_id[0];
                        if (w_rec) begin
                            r_state <= S_DIV;
                        end else begin
                            r_free[r_fcnt[IDW-1:0]] <= w_id[0];
                            r_fcnt <= r_fcnt + CW'(1);
                            r_qflag[w_id[0]] <= 1'b0;
                        end
                    end
                end
                S_DIV: begin
                    // advance past now, saturate at the top of the range
                    if (w_mdone) begin
                        r_hold.dl <= w_sum[stq_pkg::TW] ? '1 : w_sum[stq_pkg::TW-1:0];
                        r_state   <= S_INS;
                    end
                end
                S_INS: begin
                    r_cnt   <= r_cnt + CW'(1);
                    r_state <= S_CHK;
                end
                S_FIN: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
